### rtl/asr_pkg.sv
// Shared types and constants for the asymmetric speed ramp.
// Holds field widths, reset values, register indexes and phase codes.
// No dependencies.
`timescale 1ns / 1ps

package asr_pkg;

  localparam int unsigned CmdW   = 15;
  localparam int unsigned SpeedW = 17;
  localparam int unsigned StepW  = 10;
  localparam int unsigned LimitW = 16;
  localparam int unsigned PhaseW = 2;
  localparam int unsigned AddrW  = 4;
  localparam int unsigned DataW  = 32;

  localparam int unsigned InTdataW  = 32;
  localparam int unsigned OutTdataW = 24;

  localparam logic [StepW-1:0]  AccelReset = StepW'(2);
  localparam logic [StepW-1:0]  DecelReset = StepW'(10);
  localparam logic [LimitW-1:0] LimitReset = LimitW'(200);

  localparam logic [1:0] REG_ACCEL = 2'd0;
  localparam logic [1:0] REG_DECEL = 2'd1;
  localparam logic [1:0] REG_LIMIT = 2'd2;

  localparam logic [PhaseW-1:0] PHASE_STOPPED  = 2'd0;
  localparam logic [PhaseW-1:0] PHASE_STOPPING = 2'd1;
  localparam logic [PhaseW-1:0] PHASE_RUNNING  = 2'd2;
  localparam logic [PhaseW-1:0] PHASE_RESTART  = 2'd3;

  typedef struct packed {
    logic [StepW-1:0]  accel_step;
    logic [StepW-1:0]  decel_step;
    logic [LimitW-1:0] stop_speed_limit;
  } asr_cfg_t;

endpackage

### rtl/asr_cfg.sv
// Configuration register bank with an APB-style slave port.
// Depends on asr_pkg for widths, reset values and register indexes.
`timescale 1ns / 1ps

module asr_cfg
  import asr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output asr_cfg_t         cfg_o
);

  asr_cfg_t   cfg_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.accel_step       <= AccelReset;
      cfg_q.decel_step       <= DecelReset;
      cfg_q.stop_speed_limit <= LimitReset;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ACCEL: cfg_q.accel_step       <= pwdata[StepW-1:0];
        REG_DECEL: cfg_q.decel_step       <= pwdata[StepW-1:0];
        REG_LIMIT: cfg_q.stop_speed_limit <= pwdata[LimitW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ACCEL: prdata = DataW'(cfg_q.accel_step);
      REG_DECEL: prdata = DataW'(cfg_q.decel_step);
      REG_LIMIT: prdata = DataW'(cfg_q.stop_speed_limit);
      default:   prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/asr_ramp.sv
// Combinational ramp step: phase decode and next speed target.
// Depends on asr_pkg for widths, phase codes and the configuration struct.
`timescale 1ns / 1ps

module asr_ramp
  import asr_pkg::*;
(
  input  asr_cfg_t          cfg_i,
  input  logic [CmdW-1:0]   cmd_i,
  input  logic [SpeedW-1:0] speed_i,
  input  logic [CmdW-1:0]   target_i,
  output logic [CmdW-1:0]   target_o,
  output logic [PhaseW-1:0] phase_o
);

  logic [SpeedW-1:0] mag;
  logic              moving;
  logic [CmdW:0]     rise_sum;
  logic [CmdW-1:0]   rise_t;
  logic [CmdW-1:0]   decel_ext;
  logic [CmdW-1:0]   fall_t;
  logic [CmdW-1:0]   gap;
  logic [CmdW-1:0]   stop_t;
  logic [CmdW-1:0]   run_t;

  assign mag    = speed_i[SpeedW-1] ? (~speed_i + SpeedW'(1)) : speed_i;
  assign moving = mag > {1'b0, cfg_i.stop_speed_limit};

  always_comb begin
    if (cmd_i == '0) begin
      phase_o = moving ? PHASE_STOPPING : PHASE_STOPPED;
    end else begin
      phase_o = moving ? PHASE_RUNNING : PHASE_RESTART;
    end
  end

  assign rise_sum  = {1'b0, target_i} + (CmdW + 1)'(cfg_i.accel_step);
  assign rise_t    = (rise_sum > {1'b0, cmd_i}) ? cmd_i : rise_sum[CmdW-1:0];
  assign decel_ext = CmdW'(cfg_i.decel_step);
  assign fall_t    = target_i - decel_ext;
  assign gap       = target_i - cmd_i;
  assign stop_t    = (target_i > decel_ext) ? fall_t : '0;

  always_comb begin
    if (cmd_i > target_i) begin
      run_t = rise_t;
    end else if (cmd_i < target_i) begin
      run_t = (gap >= decel_ext) ? fall_t : cmd_i;
    end else begin
      run_t = target_i;
    end
  end

  always_comb begin
    case (phase_o)
      PHASE_STOPPED:  target_o = '0;
      PHASE_STOPPING: target_o = stop_t;
      PHASE_RUNNING:  target_o = run_t;
      default:        target_o = rise_t;
    endcase
  end

endmodule

### rtl/asymmetric_speed_ramp_top.sv
// Top level of the asymmetric speed ramp: stream channels, pipeline and target.
// Depends on asr_pkg, asr_cfg and asr_ramp.
//
// Usage:
// Each request on the slave stream carries a speed command and a signed
// measured speed. For every request one result leaves on the master stream:
// the ramped speed target and the phase code that chose the step.
// The configuration port holds the accel step, decel step and stop limit;
// write it only while no request is in flight.
// From slave acceptance to master valid, the request sits in the input register,
// and the ramp step then moves into the result register and the target.
// Throughput is one request per cycle while the receiver does not stall, since
// the ramp step between the input and result registers is combinational.
// When the receiver stalls, the result register holds and the input
// register keeps at most one more request before tready drops.
// Reset clears the held target to zero, empties both stages and loads the
// register reset values.
`timescale 1ns / 1ps

module asymmetric_speed_ramp_top
  import asr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // cmd_speed [14:0], measured_speed [31:15]
  input  logic [InTdataW-1:0]  s_axis_tdata_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // ramped_target [14:0], ramp_phase [16:15], zero fill [23:17]
  output logic [OutTdataW-1:0] m_axis_tdata_o,
  input  logic                 psel_i,
  input  logic                 penable_i,
  input  logic                 pwrite_i,
  input  logic [AddrW-1:0]     paddr_i,
  input  logic [DataW-1:0]     pwdata_i,
  output logic [DataW-1:0]     prdata_o,
  output logic                 pready_o
);

  asr_cfg_t          cfg;
  logic              in_valid_q;
  logic [CmdW-1:0]   cmd_q;
  logic [SpeedW-1:0] speed_q;
  logic              out_valid_q;
  logic [CmdW-1:0]   res_target_q;
  logic [PhaseW-1:0] res_phase_q;
  logic [CmdW-1:0]   target_q;
  logic [CmdW-1:0]   target_d;
  logic [PhaseW-1:0] phase_d;
  logic              advance;
  logic              in_take;

  asr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel_i),
    .penable (penable_i),
    .pwrite  (pwrite_i),
    .paddr   (paddr_i),
    .pwdata  (pwdata_i),
    .prdata  (prdata_o),
    .pready  (pready_o),
    .cfg_o   (cfg)
  );

  asr_ramp u_ramp (
    .cfg_i    (cfg),
    .cmd_i    (cmd_q),
    .speed_i  (speed_q),
    .target_i (target_q),
    .target_o (target_d),
    .phase_o  (phase_d)
  );

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      target_q    <= '0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        target_q    <= target_d;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q   <= s_axis_tdata_i[CmdW-1:0];
      speed_q <= s_axis_tdata_i[CmdW+SpeedW-1:CmdW];
    end
    if (advance) begin
      res_target_q <= target_d;
      res_phase_q  <= phase_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(OutTdataW - CmdW - PhaseW)'(0), res_phase_q, res_target_q};

  a_target_tracks_result : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    advance |=> (res_target_q == target_q)
  ) else $error("held target differs from the delivered result");

  a_stall_blocks_input : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (in_valid_q && out_valid_q && !m_axis_tready_i)
  ) else $error("input blocked without a downstream stall");

  a_stopped_is_zero : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_phase_q == PHASE_STOPPED) |-> (res_target_q == '0)
  ) else $error("stopped phase with nonzero target");

endmodule
